FILE: hdl/imuga_pkg.sv
package imuga_pkg;

  localparam int WINDOW_LENGTH_DEF = 8;

  localparam int ACC_W      = 16;
  localparam int GYRO_W     = 16;
  localparam int DIFF_W     = 17;
  localparam int RATE_W     = 41;
  localparam int EST_OUT_W  = 24;
  localparam int EST_W      = 32;
  localparam int COV_W      = 32;
  localparam int SCALE_W    = 24;
  localparam int NOISE_W    = 32;
  localparam int PMID_W     = 33;
  localparam int DEN_W      = 34;
  localparam int GAIN_FRAC  = 24;
  localparam int GAIN_W     = 25;
  localparam int GAIN_STEPS = 24;
  localparam int RATE_DIGIT_W = 8;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 26;
  localparam int PROD_W     = 60;

  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 200;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_Q     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_R     = 3'd5;

  localparam logic [SCALE_W-1:0] GYRO_SCALE_RST = 24'd17873;
  localparam logic [NOISE_W-1:0] NOISE_Q_RST    = 32'd335544;
  localparam logic [NOISE_W-1:0] NOISE_R_RST    = 32'd100663296;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN,
    ST_RMUL,
    ST_RCAP,
    ST_DINIT,
    ST_DIV,
    ST_KMUL,
    ST_KUPD,
    ST_CMUL,
    ST_CUPD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_RATE,
    MUL_KAL,
    MUL_COV
  } mul_sel_t;

  typedef struct packed {
    logic       load;
    logic       win;
    mul_sel_t   mul;
    logic [1:0] axis;
    logic       rcap;
    logic       dinit;
    logic       rate_step;
    logic       gain_step;
    logic       kupd;
    logic       cupd;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/imuga_ctrl.sv
module imuga_ctrl #(
  parameter int WINDOW_LENGTH = imuga_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [imuga_pkg::IN_USER_W-1:0]     in_tuser,
  input  imuga_pkg::sts_t                     sts,
  output imuga_pkg::cmd_t                     cmd
);
  import imuga_pkg::*;

  localparam int NUM_W = DIFF_W + $clog2(WINDOW_LENGTH) + GAIN_FRAC;
  localparam int RATE_STEPS = (NUM_W + RATE_DIGIT_W - 1) / RATE_DIGIT_W;
  localparam int STEPS = (RATE_STEPS > GAIN_STEPS) ? RATE_STEPS : GAIN_STEPS;
  localparam int CNT_W = $clog2(STEPS + 1);

  state_t             state_r, state_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 2'd0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.mul   = MUL_NONE;
    cmd.axis  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tuser[0]) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd.win   = 1'b1;
        axis_nxt  = 2'd0;
        state_nxt = ST_RMUL;
      end
      ST_RMUL: begin
        cmd.mul   = MUL_RATE;
        state_nxt = ST_RCAP;
      end
      ST_RCAP: begin
        cmd.rcap = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = ST_DINIT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_RMUL;
        end
      end
      ST_DINIT: begin
        cmd.dinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.rate_step = (cnt_r < CNT_W'(RATE_STEPS));
        cmd.gain_step = (cnt_r < CNT_W'(GAIN_STEPS));
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          cnt_nxt   = '0;
          axis_nxt  = 2'd0;
          state_nxt = ST_KMUL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_KMUL: begin
        cmd.mul   = MUL_KAL;
        state_nxt = ST_KUPD;
      end
      ST_KUPD: begin
        cmd.kupd = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = ST_CMUL;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_KMUL;
        end
      end
      ST_CMUL: begin
        cmd.mul   = MUL_COV;
        state_nxt = ST_CUPD;
      end
      ST_CUPD: begin
        cmd.cupd  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(STEPS)) else $error("divide step counter overran");

  a_axis_bound: assert property (@(posedge clk) disable iff (!rst_n)
    axis_r != 2'd3) else $error("axis counter out of range");

endmodule

FILE: hdl/imuga_datapath.sv
module imuga_datapath #(
  parameter int WINDOW_LENGTH = imuga_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  imuga_pkg::cmd_t                      cmd,
  output imuga_pkg::sts_t                      sts,
  input  logic                                 cfg_valid,
  input  logic [imuga_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [imuga_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [imuga_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [imuga_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import imuga_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W  = DIFF_W + SLOT_W;
  localparam int NUM_W  = SUM_W + GAIN_FRAC;
  localparam int REM_W  = SLOT_W;
  localparam int RATE_STEPS = (NUM_W + RATE_DIGIT_W - 1) / RATE_DIGIT_W;
  localparam int NUM_P  = RATE_STEPS * RATE_DIGIT_W;
  localparam int VAL_W  = REM_W + RATE_DIGIT_W;
  localparam int RSH    = VAL_W + REM_W;
  localparam int RPROD_W = VAL_W + RSH;
  localparam longint RECIP_V = ((longint'(1) << RSH) + longint'(WINDOW_LENGTH) - 1)
                               / longint'(WINDOW_LENGTH);
  localparam logic [RSH-1:0]    RECIP     = RSH'(RECIP_V);
  localparam logic [VAL_W-1:0]  WL_V      = VAL_W'(WINDOW_LENGTH);
  localparam logic [NUM_W-1:0]  HALF_WL   = NUM_W'(WINDOW_LENGTH / 2);
  localparam logic [REM_W:0]    WL_C      = (REM_W + 1)'(WINDOW_LENGTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LENGTH - 1);
  localparam logic [GAIN_W-1:0] ONE_Q24   = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [PROD_W-1:0] HALF_Q24  = PROD_W'(1) << (GAIN_FRAC - 1);

  logic signed [GYRO_W-1:0]   bias_r [3];
  logic [SCALE_W-1:0]         scale_r;
  logic [NOISE_W-1:0]         q_r;
  logic [NOISE_W-1:0]         rn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r[0] <= '0;
      bias_r[1] <= '0;
      bias_r[2] <= '0;
      scale_r   <= GYRO_SCALE_RST;
      q_r       <= NOISE_Q_RST;
      rn_r      <= NOISE_R_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GYRO_BIAS_X: bias_r[0] <= cfg_data[GYRO_W-1:0];
        CFG_GYRO_BIAS_Y: bias_r[1] <= cfg_data[GYRO_W-1:0];
        CFG_GYRO_BIAS_Z: bias_r[2] <= cfg_data[GYRO_W-1:0];
        CFG_GYRO_SCALE:  scale_r   <= cfg_data[SCALE_W-1:0];
        CFG_NOISE_Q:     q_r       <= cfg_data;
        CFG_NOISE_R:     rn_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample capture
  logic signed [ACC_W-1:0]  acc_r   [3];
  logic signed [DIFF_W-1:0] gdiff_r [3];
  logic signed [DIFF_W-1:0] rd_r    [3];
  logic [SLOT_W-1:0]        slot_r;
  logic                     wrapped_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        acc_r[k]   <= in_tdata[k*ACC_W +: ACC_W];
        gdiff_r[k] <= $signed({in_tdata[(k+3)*GYRO_W + GYRO_W-1],
                               in_tdata[(k+3)*GYRO_W +: GYRO_W]})
                    - $signed({bias_r[k][GYRO_W-1], bias_r[k]});
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_win
    logic [DIFF_W-1:0] mem [WINDOW_LENGTH];
    always_ff @(posedge clk) begin
      if (cmd.load) rd_r[k] <= mem[slot_r];
      if (cmd.win)  mem[slot_r] <= gdiff_r[k];
    end
  end

  // window sums; an entry not yet written reads as zero until the first wrap
  logic signed [SUM_W-1:0] sum_r [3];
  logic [COV_W-1:0]        cov_r;
  logic signed [EST_W-1:0] est_r [3];

  logic [PMID_W-1:0] pmid_r;
  logic [DEN_W-1:0]  den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      wrapped_r <= 1'b0;
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
    end else if (cmd.win) begin
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= sum_r[k] + SUM_W'(gdiff_r[k])
                  - (wrapped_r ? SUM_W'(rd_r[k]) : SUM_W'(0));
      end
      if (slot_r == SLOT_LAST) begin
        slot_r    <= '0;
        wrapped_r <= 1'b1;
      end else begin
        slot_r <= slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win)  pmid_r <= PMID_W'(cov_r) + PMID_W'(q_r);
    if (cmd.rcap) den_r  <= DEN_W'(pmid_r) + DEN_W'(rn_r);
  end

  // shared multiplier
  logic [GAIN_W-1:0]         gain_r;
  logic                      dz_r;
  logic [GAIN_W-1:0]         gain_eff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [EST_W:0]     kdiff;

  assign gain_eff = dz_r ? '0 : gain_r;

  always_comb begin
    kdiff = $signed({acc_r[cmd.axis][ACC_W-1], acc_r[cmd.axis], 16'b0})
          - $signed({est_r[cmd.axis][EST_W-1], est_r[cmd.axis]});
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      MUL_RATE: begin
        mul_a = MUL_A_W'(sum_r[cmd.axis]);
        mul_b = $signed(MUL_B_W'(scale_r));
      end
      MUL_KAL: begin
        mul_a = MUL_A_W'(kdiff);
        mul_b = $signed(MUL_B_W'(gain_eff));
      end
      MUL_COV: begin
        mul_a = $signed(MUL_A_W'(pmid_r));
        mul_b = $signed(MUL_B_W'(ONE_Q24 - gain_eff));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_NONE) prod_r <= mul_a * mul_b;
  end

  logic [PROD_W-1:0] prod_mag;
  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  // rate: long division by the window length, one 8-bit digit per step
  // by reciprocal multiply; gain divider radix 2
  logic [NUM_P-1:0]          num_r [3];
  logic                      sgn_r [3];
  logic [REM_W-1:0]          rem_r [3];
  logic [DEN_W-1:0]          grem_r;
  logic [VAL_W-1:0]          rval  [3];
  logic [RPROD_W-1:0]        rprod [3];
  logic [RATE_DIGIT_W-1:0]   rdig  [3];
  logic [VAL_W-1:0]          rsub  [3];
  logic [DEN_W:0]            g2;
  logic [DEN_W:0]            g2s;
  logic                      gge;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rval[k]  = {rem_r[k], num_r[k][NUM_P-1 -: RATE_DIGIT_W]};
      rprod[k] = RPROD_W'(rval[k]) * RPROD_W'(RECIP);
      rdig[k]  = rprod[k][RSH +: RATE_DIGIT_W];
      rsub[k]  = rval[k] - VAL_W'(rdig[k]) * WL_V;
    end
    g2  = {grem_r, 1'b0};
    gge = (g2 >= {1'b0, den_r});
    g2s = g2 - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.rcap) begin
      num_r[cmd.axis] <= NUM_P'(NUM_W'(prod_mag) + HALF_WL);
      sgn_r[cmd.axis] <= prod_r[PROD_W-1];
    end
    if (cmd.dinit) begin
      for (int k = 0; k < 3; k++) rem_r[k] <= '0;
      dz_r <= (den_r == '0);
      if (DEN_W'(pmid_r) >= den_r) begin
        gain_r <= GAIN_W'(1);
        grem_r <= DEN_W'(pmid_r) - den_r;
      end else begin
        gain_r <= '0;
        grem_r <= DEN_W'(pmid_r);
      end
    end
    if (cmd.rate_step) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= rsub[k][REM_W-1:0];
        num_r[k] <= {num_r[k][NUM_P-RATE_DIGIT_W-1:0], rdig[k]};
      end
    end
    if (cmd.gain_step) begin
      grem_r <= gge ? g2s[DEN_W-1:0] : g2[DEN_W-1:0];
      gain_r <= {gain_r[GAIN_W-2:0], gge};
    end
  end

  // Kalman update and covariance
  logic [PROD_W-1:0]       kq;
  logic signed [EST_W-1:0] kdelta;
  logic [PROD_W-GAIN_FRAC-1:0] pnew;

  always_comb begin
    kq     = (prod_mag + HALF_Q24) >> GAIN_FRAC;
    kdelta = prod_r[PROD_W-1] ? -$signed(kq[EST_W-1:0]) : $signed(kq[EST_W-1:0]);
    pnew   = prod_r[PROD_W-1:GAIN_FRAC];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) est_r[k] <= '0;
      cov_r <= '0;
    end else begin
      if (cmd.kupd) est_r[cmd.axis] <= est_r[cmd.axis] + kdelta;
      if (cmd.cupd) cov_r <= (|pnew[PROD_W-GAIN_FRAC-1:COV_W]) ? '1 : pnew[COV_W-1:0];
    end
  end

  // result register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [NUM_P:0]        rate_full [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rate_full[k] = sgn_r[k] ? -{1'b0, num_r[k]} : {1'b0, num_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata_r <= {5'b0,
                      est_r[2][EST_W-1:8], est_r[1][EST_W-1:8], est_r[0][EST_W-1:8],
                      rate_full[2][RATE_W-1:0], rate_full[1][RATE_W-1:0],
                      rate_full[0][RATE_W-1:0]};
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign sts.out_free = !out_tvalid_r || out_tready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready)) else $error("result overwritten");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul == MUL_KAL) |-> (gain_eff <= ONE_Q24)) else $error("gain above one");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rate_step |-> ({1'b0, rem_r[0]} < WL_C)) else $error("rate remainder too large");

endmodule

FILE: hdl/imu_gyro_average_acc_kalman.sv
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tdata: acc x,y,z, gyro x,y,z; tuser: sample_enable
// out_    | out | out_tvalid/out_tready| tdata: rate x,y,z, acc_est x,y,z
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An enabled item runs through load, window update, rate products per axis, divider setup,
// the 24-step radix-2 gain divider with the rate divisions (8 bits a step) inside it,
// Kalman updates per axis, covariance and result; the next item waits for the result load.
// A disabled item is taken while idle and dropped. The result waits in an output register;
// the block stalls before loading a new result while the old one is held.
// Reset is synchronous, active low; window and estimates start at zero.
module imu_gyro_average_acc_kalman #(
  parameter int WINDOW_LENGTH = imuga_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // acc_raw_x, acc_raw_y, acc_raw_z, gyro_raw_x, gyro_raw_y, gyro_raw_z
  input  logic [imuga_pkg::IN_DATA_W-1:0]  in_tdata,
  // sample_enable
  input  logic [imuga_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // rate_x, rate_y, rate_z, acc_est_x, acc_est_y, acc_est_z, zero pad
  output logic [imuga_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [imuga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imuga_pkg::CFG_DATA_W-1:0] cfg_data
);
  import imuga_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  imuga_ctrl #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  imuga_datapath #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: tb/tb_imu_gyro_average_acc_kalman.sv
`timescale 1ns / 100ps

module tb_imu_gyro_average_acc_kalman;
  import imuga_pkg::*;

  localparam int WIN = WINDOW_LENGTH_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [EST_OUT_W-1:0] est_z;
    logic signed [EST_OUT_W-1:0] est_y;
    logic signed [EST_OUT_W-1:0] est_x;
    logic signed [RATE_W-1:0]    rate_z;
    logic signed [RATE_W-1:0]    rate_y;
    logic signed [RATE_W-1:0]    rate_x;
  } imu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  imu_gyro_average_acc_kalman dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  longint bias [3];
  longint scale, noise_q, noise_r;
  longint win_mem [3][WIN];
  longint win_sum [3];
  int     slot;
  longint est_q16 [3];
  longint cov;

  imu_result_t expected_q[$];
  int  fail_cnt = 0;
  int  idle_pct = 23;
  bit  rx_hold = 1'b0;
  int  idle_cycles = 0;

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic void model_reset();
    for (int a = 0; a < 3; a++) begin
      bias[a] = 0; win_sum[a] = 0; est_q16[a] = 0;
      for (int i = 0; i < WIN; i++) win_mem[a][i] = 0;
    end
    scale = GYRO_SCALE_RST; noise_q = NOISE_Q_RST; noise_r = NOISE_R_RST;
    slot = 0; cov = 0;
  endfunction

  function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_GYRO_BIAS_X: bias[0] = longint'($signed(v[15:0]));
      CFG_GYRO_BIAS_Y: bias[1] = longint'($signed(v[15:0]));
      CFG_GYRO_BIAS_Z: bias[2] = longint'($signed(v[15:0]));
      CFG_GYRO_SCALE:  scale = longint'(v[23:0]);
      CFG_NOISE_Q:     noise_q = longint'(v);
      CFG_NOISE_R:     noise_r = longint'(v);
      default: ;
    endcase
  endfunction

  function automatic void predict_sample(logic [IN_DATA_W-1:0] d);
    imu_result_t r;
    longint diff, p_mid, den, gain, meas, e, q8;
    longint rate [3];
    longint eo [3];
    for (int a = 0; a < 3; a++) begin
      diff = longint'($signed(d[48+16*a +: 16])) - bias[a];
      win_sum[a] += diff - win_mem[a][slot];
      win_mem[a][slot] = diff;
      rate[a] = round_div(win_sum[a] * scale, WIN);
    end
    slot = (slot + 1) % WIN;
    p_mid = cov + noise_q;
    den = p_mid + noise_r;
    gain = (den == 0) ? 0 : (p_mid <<< 24) / den;
    if (gain > (64'sd1 <<< 24)) gain = 64'sd1 <<< 24;
    for (int a = 0; a < 3; a++) begin
      meas = longint'($signed(d[16*a +: 16])) * 65536;
      e = est_q16[a] + round_div((meas - est_q16[a]) * gain, 64'sd1 <<< 24);
      est_q16[a] = e;
      q8 = (e >= 0) ? e / 256 : -((-e + 255) / 256);
      eo[a] = q8;
    end
    cov = (((64'sd1 <<< 24) - gain) * p_mid) >>> 24;
    if (cov > 64'sh0FFFF_FFFF) cov = 64'sh0FFFF_FFFF;
    r.rate_x = rate[0][40:0]; r.rate_y = rate[1][40:0]; r.rate_z = rate[2][40:0];
    r.est_x = eo[0][23:0]; r.est_y = eo[1][23:0]; r.est_z = eo[2][23:0];
    expected_q.push_back(r);
  endfunction

  task automatic send_sample(bit en, logic [IN_DATA_W-1:0] d);
    while (($urandom_range(99) < idle_pct)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= en;
    do @(posedge clk); while (!in_tready);
    if (en) predict_sample(d);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [IN_DATA_W-1:0] rand_word();
    return {$urandom(), $urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_sample(1'b1, '0);
    send_sample(1'b1, {6{16'h7FFF}});
    send_sample(1'b1, {6{16'h8000}});
    send_sample(1'b0, rand_word());
    send_sample(1'b1, {6{16'hFFFF}});
    send_sample(1'b0, {6{16'h7FFF}});
    for (int i = 0; i < 10; i++) send_sample(1'b1, {{3{16'h7FFF}}, {3{16'h8000}}});
    for (int i = 0; i < 6; i++)
      send_sample(1'b1, {pick16(), pick16(), pick16(), pick16(), pick16(), pick16()});
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_GYRO_BIAS_X, 32'h0000_7FFF);
    write_reg(CFG_GYRO_BIAS_Y, 32'h0000_8000);
    write_reg(CFG_GYRO_BIAS_Z, 32'hFFFF_FFFF);
    write_reg(CFG_GYRO_SCALE, 32'h00FF_FFFF);
    write_reg(CFG_NOISE_Q, 32'hFFFF_FFFF);
    write_reg(CFG_NOISE_R, 32'hFFFF_FFFF);
    write_reg(3'd7, $urandom());
    for (int i = 0; i < 20; i++)
      send_sample(1'b1, {pick16(), pick16(), pick16(), pick16(), pick16(), pick16()});
    drain();
    // zero denominator: gain stays zero while covariance and both noises are zero
    write_reg(CFG_NOISE_Q, 32'd0);
    write_reg(CFG_NOISE_R, 32'd0);
    write_reg(CFG_GYRO_SCALE, 32'd0);
    for (int i = 0; i < 20; i++) send_sample(1'b1, rand_word());
    drain();
    write_reg(CFG_NOISE_Q, 32'd0);
    write_reg(CFG_NOISE_R, 32'd1);
    write_reg(CFG_GYRO_SCALE, 32'd1);
    for (int i = 0; i < 20; i++) send_sample(1'b1, rand_word());
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        drain();
        for (int r = 0; r < 6; r++) write_reg(r[CFG_IDX_W-1:0], $urandom());
      end
      idle_pct = (i >= 200 && i < 300) ? 0 : 23;
      send_sample($urandom_range(9) != 0,
                  {pick16(), pick16(), pick16(), pick16(), pick16(), pick16()});
    end
    drain();
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    repeat (2) @(posedge clk);
    rx_hold = 1'b0;
    for (int i = 0; i < 8; i++) send_sample(1'b1, rand_word());
    drain();
  endtask

  always @(posedge clk) begin
    int hold;
    if (rx_hold) begin
      hold = 0;
      out_tready <= 1'b0;
      while (hold < 400) begin
        @(posedge clk);
        hold++;
      end
    end else
      out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    imu_result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(imu_result_t)-1:0];
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", got);
        fail_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.rate_x !== exp_r.rate_x) begin
          $error("rate_x exp %0d got %0d", exp_r.rate_x, got.rate_x); fail_cnt++;
        end
        if (got.rate_y !== exp_r.rate_y) begin
          $error("rate_y exp %0d got %0d", exp_r.rate_y, got.rate_y); fail_cnt++;
        end
        if (got.rate_z !== exp_r.rate_z) begin
          $error("rate_z exp %0d got %0d", exp_r.rate_z, got.rate_z); fail_cnt++;
        end
        if (got.est_x !== exp_r.est_x) begin
          $error("acc_est_x exp %0d got %0d", exp_r.est_x, got.est_x); fail_cnt++;
        end
        if (got.est_y !== exp_r.est_y) begin
          $error("acc_est_y exp %0d got %0d", exp_r.est_y, got.est_y); fail_cnt++;
        end
        if (got.est_z !== exp_r.est_z) begin
          $error("acc_est_z exp %0d got %0d", exp_r.est_z, got.est_z); fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_config_extremes();
    test_random(620);
    if (fail_cnt == 0 && expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/imuga_pkg.sv
hdl/imuga_ctrl.sv
hdl/imuga_datapath.sv
hdl/imu_gyro_average_acc_kalman.sv
tb/tb_imu_gyro_average_acc_kalman.sv
